### hdl/bpa_pkg.sv
// Shared types, constants and helpers for the bitmap page allocator.
// No dependencies; used by bpa_ram users and the top level.
`timescale 1ns / 1ps

package bpa_pkg;

  // Field widths of the request and response channels
  localparam int ADDR_W     = 27;  // byte address width
  localparam int FREE_W     = 28;  // free byte count width
  localparam int CNT_W      = 16;  // free page count width
  localparam int PAGE_SHIFT = 12;  // 4 KB pages
  localparam int PG_W       = ADDR_W - PAGE_SHIFT;  // page number width
  localparam int BIT_W      = 5;   // bit index inside a 32-bit word
  localparam int WORD_BITS  = 32;
  localparam int MAX_PAGES  = 1 << PG_W;  // pages reachable by an address

  // Request function codes
  typedef enum logic [1:0] {
    FN_FREE  = 2'd0,
    FN_USED  = 2'd1,
    FN_ALLOC = 2'd2
  } func_t;

  // Index of the lowest set bit; zero when nothing is set
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### hdl/bpa_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Read data holds its value while no read is issued. No package dependency.
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/bitmap_page_allocator.sv
// Bitmap page allocator: one free bit per 4 KB page with a two-level summary.
// Depends on bpa_pkg and bpa_ram.
`timescale 1ns / 1ps

// Usage:
//   Requests enter on in_*: in_tuser holds the function (0 free a page,
//   1 mark a page used, 2 allocate), in_tdata the page byte address whose
//   low 12 bits are ignored. Each request gives one response on out_*:
//   allocated address, out-of-memory flag and free bytes after the request.
//   out_tvalid is registered in the update step. Mark requests and requests
//   that change nothing go from acceptance straight to that step; an
//   allocate passes a search step first. The block takes one request at a
//   time: in_tready is high only while idle, so a new request is not taken
//   until the last one has left its update step. An allocate reads the
//   summary word, then the bitmap word, then writes both back; a mark reads
//   both words together.
//   Reset clears the top summary flags and the free count; every page starts
//   used and no clearing pass runs, since a word whose summary flag is clear
//   reads as zero. Requests are taken right after reset.
//   A stalled response stays in the output register; the next request is
//   still accepted and waits in its final step until the register frees.

module bitmap_page_allocator #(
  parameter int PAGES = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [26:0] page_address, [31:27] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  // response channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [26:0] alloc_address, [54:27] free_bytes, [55] zero
  output logic [0:0]  out_tuser   // [0] out_of_memory
);

  localparam int EFF_PAGES = (PAGES < bpa_pkg::MAX_PAGES) ? PAGES : bpa_pkg::MAX_PAGES;
  localparam int WORDS     = (EFF_PAGES + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
  localparam int SWORDS    = (WORDS + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
  localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SA_W      = (SWORDS > 1) ? $clog2(SWORDS) : 1;
  localparam int WF_W      = bpa_pkg::PG_W - bpa_pkg::BIT_W;   // full word number
  localparam int SF_W      = WF_W - bpa_pkg::BIT_W;            // full summary number

  typedef enum logic [1:0] {ST_IDLE, ST_SRCH, ST_UPD} state_t;
  typedef enum logic [1:0] {OP_FREE, OP_USED, OP_ALLOC, OP_NOP} op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [SF_W-1:0]           s_r, s_nxt;     // summary word number
  logic [bpa_pkg::BIT_W-1:0] sb_r, sb_nxt;   // word index inside summary word
  logic [bpa_pkg::BIT_W-1:0] b_r, b_nxt;     // page bit inside bitmap word
  logic                      oom_r, oom_nxt;
  logic [SWORDS-1:0]         top_r, top_nxt;
  logic [bpa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [bpa_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [bpa_pkg::FREE_W-1:0] out_free_r, out_free_nxt;
  logic                      out_oom_r, out_oom_nxt;

  // RAM ports
  logic                      sum_rd_en, bm_rd_en, sum_wr_en, bm_wr_en;
  logic [SA_W-1:0]           sum_rd_addr, sum_wr_addr;
  logic [WA_W-1:0]           bm_rd_addr, bm_wr_addr;
  logic [31:0]               sum_rd_data, bm_rd_data, sum_wr_data, bm_wr_data;

  // Request decode
  logic [bpa_pkg::PG_W-1:0]  in_pg;
  logic [WF_W-1:0]           in_wf;
  logic [SF_W-1:0]           in_sf;
  logic                      in_range;
  logic [bpa_pkg::BIT_W-1:0] top_pick;
  logic [SF_W-1:0]           top_pick_f;
  logic [bpa_pkg::BIT_W-1:0] sum_pick;
  logic [WF_W-1:0]           srch_wf;

  // Update step
  logic                      top_bit;
  logic [31:0]               sum_word, bm_word, new_bm, new_sum, bit_mask;
  logic [bpa_pkg::BIT_W-1:0] bit_pos;
  logic                      old_bit, flip;
  logic [WF_W-1:0]           upd_wf;
  logic [bpa_pkg::PG_W-1:0]  upd_pg;
  logic                      out_free_slot;

  assign in_pg      = in_tdata[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
  assign in_wf      = in_pg[bpa_pkg::PG_W-1:bpa_pkg::BIT_W];
  assign in_sf      = in_wf[WF_W-1:bpa_pkg::BIT_W];
  assign in_range   = (32'(in_pg) < 32'(PAGES));
  assign top_pick   = bpa_pkg::lowest_set(32'(top_r));
  assign top_pick_f = SF_W'(top_pick);
  assign sum_pick   = bpa_pkg::lowest_set(sum_rd_data);
  assign srch_wf    = {s_r, sum_pick};

  // Current words: a clear summary flag means the word below reads as zero
  assign top_bit  = top_r[s_r[SA_W-1:0]];
  assign sum_word = top_bit ? sum_rd_data : '0;
  assign bm_word  = sum_word[sb_r] ? bm_rd_data : '0;
  assign bit_pos  = (op_r == OP_ALLOC) ? bpa_pkg::lowest_set(bm_word) : b_r;
  assign bit_mask = 32'(1) << bit_pos;
  assign old_bit  = bm_word[bit_pos];
  assign new_bm   = (op_r == OP_FREE) ? (bm_word | bit_mask) : (bm_word & ~bit_mask);
  assign flip     = (op_r == OP_FREE) ? !old_bit : old_bit;
  assign upd_wf   = {s_r, sb_r};
  assign upd_pg   = {upd_wf, bit_pos};

  always_comb begin
    new_sum       = sum_word;
    new_sum[sb_r] = (new_bm != '0);
  end

  assign out_free_slot = !out_valid_r || out_tready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    s_nxt         = s_r;
    sb_nxt        = sb_r;
    b_nxt         = b_r;
    oom_nxt       = oom_r;
    top_nxt       = top_r;
    cnt_nxt       = cnt_r;
    out_addr_nxt  = out_addr_r;
    out_free_nxt  = out_free_r;
    out_oom_nxt   = out_oom_r;
    out_valid_nxt = out_valid_r && !out_tready;
    sum_rd_en     = 1'b0;
    sum_rd_addr   = in_sf[SA_W-1:0];
    bm_rd_en      = 1'b0;
    bm_rd_addr    = in_wf[WA_W-1:0];
    sum_wr_en     = 1'b0;
    sum_wr_addr   = s_r[SA_W-1:0];
    sum_wr_data   = new_sum;
    bm_wr_en      = 1'b0;
    bm_wr_addr    = upd_wf[WA_W-1:0];
    bm_wr_data    = new_bm;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          s_nxt     = in_sf;
          sb_nxt    = in_pg[bpa_pkg::PG_W-1-SF_W:bpa_pkg::BIT_W];
          b_nxt     = in_pg[bpa_pkg::BIT_W-1:0];
          oom_nxt   = 1'b0;
          op_nxt    = OP_NOP;
          state_nxt = ST_UPD;
          case (in_tuser)
            bpa_pkg::FN_FREE, bpa_pkg::FN_USED: begin
              if (in_range) begin
                op_nxt    = (in_tuser == bpa_pkg::FN_FREE) ? OP_FREE : OP_USED;
                sum_rd_en = 1'b1;
                bm_rd_en  = 1'b1;
              end
            end
            bpa_pkg::FN_ALLOC: begin
              if (top_r != '0) begin
                op_nxt      = OP_ALLOC;
                s_nxt       = top_pick_f;
                sum_rd_en   = 1'b1;
                sum_rd_addr = top_pick_f[SA_W-1:0];
                state_nxt   = ST_SRCH;
              end else begin
                oom_nxt = 1'b1;
              end
            end
            default: begin
              op_nxt = OP_NOP;
            end
          endcase
        end
      end
      ST_SRCH: begin
        // summary word is known nonzero here
        sb_nxt     = sum_pick;
        bm_rd_en   = 1'b1;
        bm_rd_addr = srch_wf[WA_W-1:0];
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        if (out_free_slot) begin
          if (op_r != OP_NOP) begin
            sum_wr_en = 1'b1;
            bm_wr_en  = 1'b1;
            top_nxt[s_r[SA_W-1:0]] = (new_sum != '0);
            if (flip) begin
              cnt_nxt = (op_r == OP_FREE) ? cnt_r + 1'b1 : cnt_r - 1'b1;
            end
          end
          out_addr_nxt  = (op_r == OP_ALLOC) ?
                          {upd_pg, bpa_pkg::PAGE_SHIFT'(0)} : '0;
          out_oom_nxt   = oom_r;
          out_free_nxt  = (op_r == OP_NOP || !flip) ? {cnt_r, bpa_pkg::PAGE_SHIFT'(0)} :
                          {cnt_nxt, bpa_pkg::PAGE_SHIFT'(0)};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    s_r        <= s_nxt;
    sb_r       <= sb_nxt;
    b_r        <= b_nxt;
    oom_r      <= oom_nxt;
    out_addr_r <= out_addr_nxt;
    out_free_r <= out_free_nxt;
    out_oom_r  <= out_oom_nxt;
  end

  // Summary level: one flag per bitmap word
  bpa_ram #(
    .DEPTH(SWORDS),
    .AW   (SA_W),
    .DW   (bpa_pkg::WORD_BITS)
  ) u_sum_ram (
    .clk    (clk),
    .rd_en  (sum_rd_en),
    .rd_addr(sum_rd_addr),
    .rd_data(sum_rd_data),
    .wr_en  (sum_wr_en),
    .wr_addr(sum_wr_addr),
    .wr_data(sum_wr_data)
  );

  // Page bitmap: one free bit per page
  bpa_ram #(
    .DEPTH(WORDS),
    .AW   (WA_W),
    .DW   (bpa_pkg::WORD_BITS)
  ) u_bm_ram (
    .clk    (clk),
    .rd_en  (bm_rd_en),
    .rd_addr(bm_rd_addr),
    .rd_data(bm_rd_data),
    .wr_en  (bm_wr_en),
    .wr_addr(bm_wr_addr),
    .wr_data(bm_wr_data)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_free_r, out_addr_r};
  assign out_tuser  = out_oom_r;

endmodule
